// File: hdl/assert_macros.svh
// Assertion helpers for the mailbox register core.
// ASSERT_RST checks a property on every rising edge outside reset.
// ASSERT_CLK checks a property on every rising edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rstn, prop)

`define ASSERT_CLK(label, clk, prop)

`endif

`endif

// File: hdl/mir_pkg.sv
package mir_pkg;

    localparam int DATA_W          = 32;
    localparam int SEL_W           = 4;
    localparam int ERR_W           = 2;
    localparam int SOURCE_BITS_DEF = 32;

    typedef logic [SEL_W-1:0] sel_t;
    typedef logic [ERR_W-1:0] err_t;
    typedef logic [2:0]       role_t;

    // Register map
    localparam sel_t REG_CTRL   = 4'd0;
    localparam sel_t REG_GEN0   = 4'd1;
    localparam sel_t REG_CLR0   = 4'd2;
    localparam sel_t REG_MASK0  = 4'd3;
    localparam sel_t REG_STAT0  = 4'd4;
    localparam sel_t REG_MSTAT0 = 4'd5;
    localparam sel_t REG_GEN1   = 4'd6;
    localparam sel_t REG_CLR1   = 4'd7;
    localparam sel_t REG_MASK1  = 4'd8;
    localparam sel_t REG_STAT1  = 4'd9;
    localparam sel_t REG_MSTAT1 = 4'd10;

    // Register role inside a bank
    localparam role_t ROLE_CTRL  = 3'd0;
    localparam role_t ROLE_GEN   = 3'd1;
    localparam role_t ROLE_CLR   = 3'd2;
    localparam role_t ROLE_MASK  = 3'd3;
    localparam role_t ROLE_STAT  = 3'd4;
    localparam role_t ROLE_MSTAT = 3'd5;
    localparam role_t ROLE_NONE  = 3'd6;

    // Access error codes
    localparam err_t ERR_OK      = 2'd0;
    localparam err_t ERR_WO_READ = 2'd1;
    localparam err_t ERR_RO_WRITE = 2'd2;
    localparam err_t ERR_NO_REG  = 2'd3;

    localparam logic KIND_WRITE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic take;   // accept the input beat, update state, load result
    } mir_cmd_t;

endpackage

// File: hdl/mir_ctrl.sv
module mir_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mir_pkg::mir_cmd_t cmd
);
    import mir_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;

    // Take a new beat when the result slot is empty or drains this cycle
    assign s_ready  = (state_reg == ST_EMPTY) || m_ready;
    assign cmd.take = s_valid && s_ready;
    assign m_valid  = (state_reg == ST_FULL);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: begin
                if (cmd.take) state_next = ST_FULL;
            end
            ST_FULL: begin
                if (cmd.take)     state_next = ST_FULL;
                else if (m_ready) state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/mir_datapath.sv
module mir_datapath #(
    parameter int SOURCE_BITS = mir_pkg::SOURCE_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mir_pkg::mir_cmd_t         cmd,
    input  logic                      s_kind,
    input  logic [mir_pkg::SEL_W-1:0] s_reg_select,
    input  logic [mir_pkg::DATA_W-1:0] s_write_data,
    output logic [mir_pkg::DATA_W-1:0] m_read_data,
    output logic [mir_pkg::ERR_W-1:0] m_access_error,
    output logic                      m_doorbell_set,
    output logic                      m_doorbell_clear,
    output logic [mir_pkg::DATA_W-1:0] m_host_pending
);
    import mir_pkg::*;

    typedef logic [SOURCE_BITS-1:0] src_t;

    localparam src_t ALL_ONES = '1;

    // Architectural state
    logic [DATA_W-1:0] ctrl_reg, ctrl_next;
    src_t gen_reg  [2], gen_next  [2];
    src_t clr_reg  [2], clr_next  [2];
    src_t mask_reg [2], mask_next [2];
    src_t stat_reg [2], stat_next [2];
    src_t en_reg   [2], en_next   [2];

    // Result register
    logic [DATA_W-1:0] rd_reg, rd_next;
    err_t              err_reg, err_next;
    logic              dset_reg, dset_next;
    logic              dclr_reg, dclr_next;
    logic [DATA_W-1:0] host_reg, host_next;

    role_t role;
    logic  bank;
    logic  wr;
    src_t  v;
    src_t  hit;

    always_comb begin
        unique case (s_reg_select) inside
            REG_CTRL:              role = ROLE_CTRL;
            REG_GEN0, REG_GEN1:    role = ROLE_GEN;
            REG_CLR0, REG_CLR1:    role = ROLE_CLR;
            REG_MASK0, REG_MASK1:  role = ROLE_MASK;
            REG_STAT0, REG_STAT1:  role = ROLE_STAT;
            REG_MSTAT0, REG_MSTAT1: role = ROLE_MSTAT;
            default:               role = ROLE_NONE;
        endcase
    end

    assign bank = (s_reg_select > REG_MSTAT0);
    assign wr   = (s_kind == KIND_WRITE);
    assign v    = s_write_data[SOURCE_BITS-1:0];

    always_comb begin
        ctrl_next = ctrl_reg;
        rd_next   = '0;
        err_next  = ERR_OK;
        dset_next = 1'b0;
        dclr_next = 1'b0;
        hit       = '0;

        for (int b = 0; b < 2; b++) begin
            gen_next[b]  = gen_reg[b];
            clr_next[b]  = clr_reg[b];
            mask_next[b] = mask_reg[b];
            stat_next[b] = stat_reg[b];
            en_next[b]   = en_reg[b];
        end

        // Error codes
        if (role == ROLE_NONE) begin
            err_next = ERR_NO_REG;
        end else if (!wr && role == ROLE_CLR) begin
            err_next = ERR_WO_READ;
        end else if (wr && (role == ROLE_STAT || role == ROLE_MSTAT)) begin
            err_next = ERR_RO_WRITE;
        end

        if (!wr) begin
            case (role)
                ROLE_CTRL:  rd_next = ctrl_reg;
                ROLE_GEN:   rd_next = DATA_W'(gen_reg[bank]);
                ROLE_MASK:  rd_next = DATA_W'(mask_reg[bank]);
                ROLE_STAT:  rd_next = DATA_W'(stat_reg[bank]);
                ROLE_MSTAT: rd_next = DATA_W'(en_reg[bank]);
                default:    rd_next = '0;
            endcase
        end else if (role == ROLE_CTRL) begin
            ctrl_next = s_write_data;
        end else begin
            for (int b = 0; b < 2; b++) begin
                if (bank == 1'(b)) begin
                    case (role)
                        ROLE_GEN: begin
                            hit          = v & en_reg[b];
                            stat_next[b] = v;
                            gen_next[b]  = v;
                            if (|(hit & clr_reg[b])) begin
                                clr_next[b] = clr_reg[b] & ~hit;
                                if (b == 0) dset_next = 1'b1;
                            end
                        end
                        ROLE_CLR: begin
                            gen_next[b]  = gen_reg[b] & ~v;
                            stat_next[b] = stat_reg[b] & ~v;
                            clr_next[b]  = clr_reg[b] | v;
                            if (b == 0) dclr_next = 1'b1;
                        end
                        ROLE_MASK: begin
                            mask_next[b] = v;
                            en_next[b]   = ~v;
                        end
                        default: ;
                    endcase
                end
            end
        end

        host_next = DATA_W'(stat_next[1] & en_next[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            for (int b = 0; b < 2; b++) begin
                gen_reg[b]  <= '0;
                clr_reg[b]  <= ALL_ONES;
                mask_reg[b] <= '0;
                stat_reg[b] <= '0;
                en_reg[b]   <= ALL_ONES;
            end
        end else if (cmd.take) begin
            ctrl_reg <= ctrl_next;
            for (int b = 0; b < 2; b++) begin
                gen_reg[b]  <= gen_next[b];
                clr_reg[b]  <= clr_next[b];
                mask_reg[b] <= mask_next[b];
                stat_reg[b] <= stat_next[b];
                en_reg[b]   <= en_next[b];
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            rd_reg   <= rd_next;
            err_reg  <= err_next;
            dset_reg <= dset_next;
            dclr_reg <= dclr_next;
            host_reg <= host_next;
        end
    end

    assign m_read_data      = rd_reg;
    assign m_access_error   = err_reg;
    assign m_doorbell_set   = dset_reg;
    assign m_doorbell_clear = dclr_reg;
    assign m_host_pending   = host_reg;

endmodule

// File: hdl/mailbox_interrupt_registers_core.sv
// Mailbox interrupt register core: takes one register access per beat (read or
// write, a 4-bit register select and 32-bit write data) and returns one result
// beat with read data, an access error code, the device doorbell set/clear
// pulses and the host pending word (host status AND host mask-status after the
// access). The register update and the result are computed in the same cycle
// the input beat is accepted and the result lands in a single output register,
// which sets the rate. A new access is accepted every cycle as long as the
// result register is empty or drains in that cycle, so the sustained rate is
// one beat per cycle while m_ready stays high. All register-file state is in
// flip-flops that reset sets directly to the post-init values (clear and
// mask-status all ones, everything else zero); there is no clearing pass.
// SOURCE_BITS sets how many interrupt sources each bank word holds; upper bits
// read back as zero and are ignored on writes to bank registers.
`include "assert_macros.svh"

module mailbox_interrupt_registers_core #(
    parameter int SOURCE_BITS = mir_pkg::SOURCE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [mir_pkg::SEL_W-1:0]  s_reg_select,
    input  logic [mir_pkg::DATA_W-1:0] s_write_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [mir_pkg::DATA_W-1:0] m_read_data,
    output logic [mir_pkg::ERR_W-1:0]  m_access_error,
    output logic                       m_doorbell_set,
    output logic                       m_doorbell_clear,
    output logic [mir_pkg::DATA_W-1:0] m_host_pending
);
    import mir_pkg::*;

    mir_cmd_t cmd;

    // Handshake control: one result slot, refilled as it drains
    mir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Register file, access decode and result register
    mir_datapath #(
        .SOURCE_BITS (SOURCE_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_kind           (s_kind),
        .s_reg_select     (s_reg_select),
        .s_write_data     (s_write_data),
        .m_read_data      (m_read_data),
        .m_access_error   (m_access_error),
        .m_doorbell_set   (m_doorbell_set),
        .m_doorbell_clear (m_doorbell_clear),
        .m_host_pending   (m_host_pending)
    );

    // A clear write and a generate write are distinct accesses: never both pulses
    `ASSERT_RST(a_doorbell_excl, aclk, aresetn, m_valid |-> !(m_doorbell_set && m_doorbell_clear))

    // Failed accesses return zero data
    `ASSERT_RST(a_err_zero_data, aclk, aresetn, (m_valid && m_access_error != ERR_OK) |-> (m_read_data == '0))

    // An accepted beat always produces a result on the next cycle
    `ASSERT_RST(a_take_fills, aclk, aresetn, (aresetn && s_valid && s_ready) |=> m_valid)

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import mir_pkg::*;

    localparam int          SOURCE_BITS    = SOURCE_BITS_DEF;
    localparam logic [31:0] SRC_MASK       = (SOURCE_BITS >= 32) ? 32'hFFFF_FFFF
                                             : ((32'd1 << SOURCE_BITS) - 32'd1);
    localparam logic        KIND_READ      = 1'b0;
    localparam int          RESET_CYCLES   = 12;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          ITEMS_PER_PHASE = 300;
    localparam int          NUM_PHASES     = 4;

    // One result beat as the block returns it.
    typedef struct packed {
        logic [31:0] read_data;
        err_t        access_error;
        logic        doorbell_set;
        logic        doorbell_clear;
        logic [31:0] host_pending;
    } access_result_t;

    // One row of the directed table. Rows with fixed set carry a typed-in
    // expectation; all other rows are checked against the predictor.
    typedef struct {
        logic           kind;
        sel_t           sel;
        logic [31:0]    data;
        logic           fixed;
        access_result_t want;
    } access_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_READ;
    sel_t        s_reg_select = REG_CTRL;
    logic [31:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    err_t        m_access_error;
    logic        m_doorbell_set;
    logic        m_doorbell_clear;
    logic [31:0] m_host_pending;

    // Typed-in expectation that travels with the beat on the input channel.
    logic           beat_fixed = 1'b0;
    access_result_t beat_want = '0;

    // Predictor copy of the register state.
    logic [31:0] ctrl_q;
    logic [31:0] gen_q   [2];
    logic [31:0] clr_q   [2];
    logic [31:0] mask_q  [2];
    logic [31:0] stat_q  [2];
    logic [31:0] en_q    [2];

    access_result_t pending_results[$];
    access_row_t    directed_rows[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int err_count = 0;
    int result_index = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_err_beats = 0;
    int n_dset = 0;
    int n_dclr = 0;

    mailbox_interrupt_registers_core #(
        .SOURCE_BITS(SOURCE_BITS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_reg_select    (s_reg_select),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_access_error  (m_access_error),
        .m_doorbell_set  (m_doorbell_set),
        .m_doorbell_clear(m_doorbell_clear),
        .m_host_pending  (m_host_pending)
    );

    always #5 aclk = ~aclk;

    // Apply one register access to the predictor state and return the
    // result beat it should produce.
    function automatic access_result_t predict_access(input logic kind, input sel_t sel,
                                                      input logic [31:0] data);
        access_result_t res;
        int             bank;
        logic [31:0]    v;
        logic [31:0]    hit;
        res  = '0;
        bank = (sel <= REG_MSTAT0) ? 0 : 1;
        v    = data & SRC_MASK;
        case (sel)
            REG_CTRL: begin
                if (kind == KIND_WRITE) ctrl_q = data;
                else                    res.read_data = ctrl_q;
            end
            REG_GEN0, REG_GEN1: begin
                if (kind == KIND_WRITE) begin
                    // Consume clear bits only for unmasked sources that are armed.
                    hit = v & en_q[bank];
                    stat_q[bank] = v;
                    if ((hit & clr_q[bank]) != '0) begin
                        clr_q[bank] = ~hit & clr_q[bank] & SRC_MASK;
                        if (bank == 0) res.doorbell_set = 1'b1;
                    end
                    gen_q[bank] = v;
                end else begin
                    res.read_data = gen_q[bank];
                end
            end
            REG_CLR0, REG_CLR1: begin
                if (kind == KIND_WRITE) begin
                    gen_q[bank]  = gen_q[bank] & ~v;
                    stat_q[bank] = stat_q[bank] & ~v;
                    clr_q[bank]  = (clr_q[bank] | v) & SRC_MASK;
                    if (bank == 0) res.doorbell_clear = 1'b1;
                end else begin
                    res.access_error = ERR_WO_READ;
                end
            end
            REG_MASK0, REG_MASK1: begin
                if (kind == KIND_WRITE) begin
                    mask_q[bank] = v;
                    en_q[bank]   = ~v & SRC_MASK;
                end else begin
                    res.read_data = mask_q[bank];
                end
            end
            REG_STAT0, REG_STAT1: begin
                if (kind == KIND_WRITE) res.access_error = ERR_RO_WRITE;
                else                    res.read_data = stat_q[bank];
            end
            REG_MSTAT0, REG_MSTAT1: begin
                if (kind == KIND_WRITE) res.access_error = ERR_RO_WRITE;
                else                    res.read_data = en_q[bank];
            end
            default: res.access_error = ERR_NO_REG;
        endcase
        res.host_pending = stat_q[1] & en_q[1];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s at result %0d: got %h, want %h",
                 $realtime, field, result_index, got, want);
        err_count++;
    endtask

    task automatic add_row(input logic kind, input sel_t sel, input logic [31:0] data,
                           input logic fixed, input logic [31:0] rd, input err_t err);
        access_row_t row;
        row.kind  = kind;
        row.sel   = sel;
        row.data  = data;
        row.fixed = fixed;
        row.want  = '0;
        row.want.read_data    = rd;
        row.want.access_error = err;
        directed_rows.push_back(row);
    endtask

    // Present one beat on the input channel and hold it until accepted.
    // Any idle gap is decided first so that s_valid gets one assignment per edge.
    task automatic send_access(input logic kind, input sel_t sel, input logic [31:0] data,
                               input logic fixed, input access_result_t want);
        bit gap;
        gap = 1'b1;
        while (gap) begin
            gap = (send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct);
            if (gap) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_reg_select <= sel;
        s_write_data <= data;
        beat_fixed   <= fixed;
        beat_want    <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Draw a random access, weighted toward the generate, clear and mask
    // registers so that interrupts get raised, masked and re-armed often.
    task automatic random_access(output logic kind, output sel_t sel,
                                 output logic [31:0] data);
        int pick;
        pick = $urandom_range(99);
        kind = ($urandom_range(99) < 60) ? KIND_WRITE : KIND_READ;
        if (pick < 6) begin
            sel = sel_t'($urandom_range(15, 11));
        end else if (pick < 46) begin
            case ($urandom_range(5))
                0:       sel = REG_GEN0;
                1:       sel = REG_CLR0;
                2:       sel = REG_MASK0;
                3:       sel = REG_GEN1;
                4:       sel = REG_CLR1;
                default: sel = REG_MASK1;
            endcase
        end else begin
            sel = sel_t'($urandom_range(10));
        end
        case ($urandom_range(7))
            0:       data = 32'h0000_0000;
            1:       data = 32'hFFFF_FFFF;
            2:       data = 32'd1 << $urandom_range(31);
            3:       data = $urandom & $urandom & $urandom;
            default: data = $urandom;
        endcase
    endtask

    // Receiver side: stall at the phase's rate.
    always @(posedge aclk) begin
        if (recv_stall_pct == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check the result beat against the oldest expectation, then
    // push the expectation for any input beat taken at the same edge.
    always @(posedge aclk) begin
        access_result_t want;
        access_result_t pred;
        if (!aresetn) begin
            ctrl_q = '0;
            for (int b = 0; b < 2; b++) begin
                gen_q[b]  = '0;
                clr_q[b]  = 32'hFFFF_FFFF & SRC_MASK;
                mask_q[b] = '0;
                stat_q[b] = '0;
                en_q[b]   = 32'hFFFF_FFFF & SRC_MASK;
            end
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_read_data, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", m_read_data, want.read_data);
                    if (m_access_error !== want.access_error)
                        report_mismatch("access_error", 32'(m_access_error),
                                        32'(want.access_error));
                    if (m_doorbell_set !== want.doorbell_set)
                        report_mismatch("doorbell_set", 32'(m_doorbell_set),
                                        32'(want.doorbell_set));
                    if (m_doorbell_clear !== want.doorbell_clear)
                        report_mismatch("doorbell_clear", 32'(m_doorbell_clear),
                                        32'(want.doorbell_clear));
                    if (m_host_pending !== want.host_pending)
                        report_mismatch("host_pending", m_host_pending, want.host_pending);
                end
                if (m_access_error != ERR_OK) n_err_beats++;
                if (m_doorbell_set)           n_dset++;
                if (m_doorbell_clear)         n_dclr++;
                result_index++;
            end
            if (s_valid && s_ready) begin
                // Advance the predictor on every beat, fixed rows included.
                pred = predict_access(s_kind, s_reg_select, s_write_data);
                pending_results.push_back(beat_fixed ? beat_want : pred);
                if (s_kind == KIND_WRITE) n_writes++;
                else                      n_reads++;
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic           kind;
        sel_t           sel;
        logic [31:0]    data;
        access_result_t none;
        none = '0;

        // Directed table. Fixed rows cover reset values and every error code,
        // all taken while the host bank is still idle.
        add_row(KIND_READ,  REG_CTRL,   32'h0,          1'b1, 32'h0000_0000, ERR_OK);
        add_row(KIND_READ,  REG_GEN0,   32'h0,          1'b1, 32'h0000_0000, ERR_OK);
        add_row(KIND_READ,  REG_MASK0,  32'h0,          1'b1, 32'h0000_0000, ERR_OK);
        add_row(KIND_READ,  REG_MSTAT0, 32'h0,          1'b1, SRC_MASK,      ERR_OK);
        add_row(KIND_READ,  REG_STAT1,  32'h0,          1'b1, 32'h0000_0000, ERR_OK);
        add_row(KIND_READ,  REG_CLR0,   32'h0,          1'b1, 32'h0000_0000, ERR_WO_READ);
        add_row(KIND_WRITE, REG_STAT0,  32'hFFFF_FFFF,  1'b1, 32'h0000_0000, ERR_RO_WRITE);
        add_row(KIND_WRITE, REG_MSTAT1, 32'hFFFF_FFFF,  1'b1, 32'h0000_0000, ERR_RO_WRITE);
        add_row(KIND_READ,  sel_t'(15), 32'h0,          1'b1, 32'h0000_0000, ERR_NO_REG);
        add_row(KIND_WRITE, sel_t'(11), 32'hFFFF_FFFF,  1'b1, 32'h0000_0000, ERR_NO_REG);
        add_row(KIND_WRITE, REG_CTRL,   32'hFFFF_FFFF,  1'b1, 32'h0000_0000, ERR_OK);
        add_row(KIND_READ,  REG_CTRL,   32'h0,          1'b1, 32'hFFFF_FFFF, ERR_OK);
        // Raise every device source, then repeat it with nothing newly armed.
        add_row(KIND_WRITE, REG_GEN0,   32'hFFFF_FFFF,  1'b0, '0, ERR_OK);
        add_row(KIND_WRITE, REG_GEN0,   32'hFFFF_FFFF,  1'b0, '0, ERR_OK);
        add_row(KIND_READ,  REG_STAT0,  32'h0,          1'b0, '0, ERR_OK);
        add_row(KIND_READ,  REG_GEN0,   32'h0,          1'b0, '0, ERR_OK);
        add_row(KIND_WRITE, REG_CLR0,   32'h0000_FFFF,  1'b0, '0, ERR_OK);
        add_row(KIND_READ,  REG_STAT0,  32'h0,          1'b0, '0, ERR_OK);
        // Host bank: mask the upper half, raise all, drop one, no doorbells.
        add_row(KIND_WRITE, REG_MASK1,  32'hFFFF_0000,  1'b0, '0, ERR_OK);
        add_row(KIND_READ,  REG_MSTAT1, 32'h0,          1'b0, '0, ERR_OK);
        add_row(KIND_WRITE, REG_GEN1,   32'hFFFF_FFFF,  1'b0, '0, ERR_OK);
        add_row(KIND_READ,  REG_MASK1,  32'h0,          1'b0, '0, ERR_OK);
        add_row(KIND_WRITE, REG_CLR1,   32'h0000_0001,  1'b0, '0, ERR_OK);
        // Masked device source with its clear bit armed: no doorbell.
        add_row(KIND_WRITE, REG_MASK0,  32'h8000_0001,  1'b0, '0, ERR_OK);
        add_row(KIND_WRITE, REG_GEN0,   32'h0000_0001,  1'b0, '0, ERR_OK);

        // Hold reset, then release it once.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_access(directed_rows[i].kind, directed_rows[i].sel, directed_rows[i].data,
                        directed_rows[i].fixed, directed_rows[i].want);
        end

        // Random part across the idling phases.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_access(kind, sel, data);
                send_access(kind, sel, data, 1'b0, none);
            end
        end

        // Drop valid, drain the outstanding results and let the block settle.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned", pending_results.size(), '0);

        $display("covered %0d reads and %0d writes; %0d results checked", n_reads, n_writes,
                 result_index);
        $display("saw %0d error beats, %0d doorbell sets, %0d doorbell clears", n_err_beats,
                 n_dset, n_dclr);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
